FILE: rtl/bb3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants for the 3x3 box blur
// Pixel, window and job types passed from the front end through the job
// queue to the back end, plus configuration register indexes.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int POS_W       = 9;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  // floor(s / 9) == (s * RECIP_9) >> RECIP_SHIFT for every s below 2296
  localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 10'd512;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pixel_t;

  // win[i][j]: row i (0 is oldest row), column j (0 is oldest column)
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  // One axis of the output block caused by a pixel
  typedef struct packed {
    logic [POS_W-1:0] base;  // first emitted row or column
    logic [1:0]       off;   // window offset of that first row or column
    logic [1:0]       last;  // emitted count minus one
  } span_t;

  typedef struct packed {
    window_t win;
    span_t   rows;
    span_t   cols;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

FILE: rtl/bb3_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_front: pixel intake, line store and window
// Tracks the raster position, reads and rewrites the two-row line store,
// shifts the 3x3 window and pushes a job for every pixel that emits results.
// ----------------------------------------------------------------------------
module bb3_front #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]     w,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]    h,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [bb3_pkg::CH_W-1:0]           red,
  input  wire logic [bb3_pkg::CH_W-1:0]           green,
  input  wire logic [bb3_pkg::CH_W-1:0]           blue,
  input  wire logic                               frame_start,
  input  wire bb3_pkg::q_stat_t                   q_stat,
  output logic                                    push,
  output bb3_pkg::job_t                           job
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WDW = $clog2(MAX_WIDTH + 1);
  localparam int HDW = $clog2(MAX_HEIGHT + 1);
  localparam int PW  = bb3_pkg::PIX_W;

  // Position of the next pixel
  logic [CW-1:0] col;
  logic [RW-1:0] row;

  // Current pixel position and next position
  logic [CW-1:0] c0, c, col_next;
  logic [RW-1:0] r0, r, row_next;
  logic          c_last, r_last, c_ge2, r_ge2;
  logic          emit;
  bb3_pkg::span_t col_span, row_span;

  // Stage A: accepted pixel waiting for its line store data
  logic                a_valid;
  bb3_pkg::pixel_t     a_px;
  logic [CW-1:0]       a_addr;
  logic                a_emit;
  bb3_pkg::span_t      a_rows, a_cols;
  logic                a_hit;
  logic [2*PW-1:0]     a_fwd;

  logic                a_adv, acc;
  logic [2*PW-1:0]     lines, wdata;
  logic [2*PW-1:0]     rd_q;
  logic [2*PW-1:0]     mem [MAX_WIDTH];

  bb3_pkg::window_t    win, win_next;

  // Saturate the position and classify the pixel
  always_comb begin
    c0 = frame_start ? '0 : col;
    r0 = frame_start ? '0 : row;
    c  = (WDW'(c0) >= w) ? CW'(w - WDW'(1)) : c0;
    r  = (HDW'(r0) >= h) ? RW'(h - HDW'(1)) : r0;
    c_last = (WDW'(c) == w - WDW'(1));
    r_last = (HDW'(r) == h - HDW'(1));
    c_ge2  = (c >= CW'(2));
    r_ge2  = (r >= RW'(2));

    col_span.base = c_ge2 ? bb3_pkg::POS_W'(c - CW'(2)) : '0;
    col_span.off  = c_ge2 ? 2'd0 : 2'd2 - c[1:0];
    col_span.last = c_last ? (c_ge2 ? 2'd2 : c[1:0]) : 2'd0;
    row_span.base = r_ge2 ? bb3_pkg::POS_W'(r - RW'(2)) : '0;
    row_span.off  = r_ge2 ? 2'd0 : 2'd2 - r[1:0];
    row_span.last = r_last ? (r_ge2 ? 2'd2 : r[1:0]) : 2'd0;
    emit = (c_last || c_ge2) && (r_last || r_ge2);

    if (c_last) begin
      col_next = '0;
      row_next = r_last ? '0 : r + RW'(1);
    end else begin
      col_next = c + CW'(1);
      row_next = r;
    end
  end

  // Handshake: stage A drains into the window and the job queue
  assign a_adv    = a_valid && (!a_emit || !q_stat.full);
  assign in_stall = a_valid && !a_adv;
  assign acc      = in_valid && !in_stall;

  // Line store data with forwarding of a same-edge write
  assign lines = a_hit ? a_fwd : rd_q;
  assign wdata = {lines[PW-1:0], a_px};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i][0] = win[i][1];
      win_next[i][1] = win[i][2];
    end
    win_next[0][2] = lines[2*PW-1:PW];
    win_next[1][2] = lines[PW-1:0];
    win_next[2][2] = a_px;
  end

  assign push     = a_adv && a_emit;
  assign job.win  = win_next;
  assign job.rows = a_rows;
  assign job.cols = a_cols;

  // Advance position counters and track stage A occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      a_valid <= 1'b0;
    end else begin
      if (acc) begin
        col <= col_next;
        row <= row_next;
      end
      if (acc) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
    end
  end

  // Capture stage A payload
  always_ff @(posedge clk) begin
    if (acc) begin
      a_px   <= {red, green, blue};
      a_addr <= c;
      a_emit <= emit;
      a_rows <= row_span;
      a_cols <= col_span;
      a_hit  <= a_adv && (a_addr == c);
      a_fwd  <= wdata;
    end
  end

  // Line store: read on accept, write back when stage A drains
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_q <= mem[c];
    end
    if (a_adv) begin
      mem[a_addr] <= wdata;
    end
  end

  // Shift the window
  always_ff @(posedge clk) begin
    if (a_adv) begin
      win <= win_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bb3_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_queue: job queue between front and back end
// Small register FIFO; the head entry is visible without a pop.
// ----------------------------------------------------------------------------
module bb3_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire bb3_pkg::job_t     push_job,
  input  wire logic              pop,
  output bb3_pkg::job_t          head,
  output bb3_pkg::q_stat_t       stat
);

  localparam int DEPTH = bb3_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  bb3_pkg::job_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign head       = entries[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (PTR_W+1)'(DEPTH));

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bb3_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_back: result sequencer and blur datapath
// Walks the output block of the head job one result per cycle while the output
// is not stalled, sums the nine selected window pixels, divides by nine and
// holds the result.
module bb3_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bb3_pkg::job_t              head,
  input  wire bb3_pkg::q_stat_t           q_stat,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [bb3_pkg::CH_W-1:0]        out_red,
  output logic [bb3_pkg::CH_W-1:0]        out_green,
  output logic [bb3_pkg::CH_W-1:0]        out_blue,
  output logic [bb3_pkg::POS_W-1:0]       out_row,
  output logic [bb3_pkg::POS_W-1:0]       out_col,
  output logic                            last_of_run
);

  localparam int CH  = bb3_pkg::CH_W;
  localparam int SW  = bb3_pkg::SUM_W;
  localparam int PRW = bb3_pkg::SUM_W + bb3_pkg::RECIP_W;

  function automatic logic [CH-1:0] div9(input logic [SW-1:0] s);
    logic [PRW-1:0] p;
    p = PRW'(s) * PRW'(bb3_pkg::RECIP_9);
    return p[bb3_pkg::RECIP_SHIFT +: CH];
  endfunction

  // Position inside the current output block
  logic [1:0] i_q, j_q;

  logic [1:0]         dy, dx;
  logic [2:0][1:0]    ri, cj;
  logic [2:0]         t;
  logic [SW-1:0]      sum_r, sum_g, sum_b;
  bb3_pkg::pixel_t    p;
  logic               is_last, issue, s_ready, o_ready;

  // Sum stage
  logic                          s_valid;
  logic [SW-1:0]                 s_r, s_g, s_b;
  logic [bb3_pkg::POS_W-1:0]     s_row, s_col;
  logic                          s_last;

  // Pick window rows and columns (past the image edge reuse the base) and sum the nine pixels
  always_comb begin
    dy = head.rows.off + i_q;
    dx = head.cols.off + j_q;
    for (int k = 0; k < 3; k++) begin
      t = {1'b0, dy} + 3'(k);
      ri[k] = (t > 3'd2) ? dy : t[1:0];
      t = {1'b0, dx} + 3'(k);
      cj[k] = (t > 3'd2) ? dx : t[1:0];
    end
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 3; m++) begin
        p = head.win[ri[k]][cj[m]];
        sum_r = sum_r + SW'(p[3*CH-1:2*CH]);
        sum_g = sum_g + SW'(p[2*CH-1:CH]);
        sum_b = sum_b + SW'(p[CH-1:0]);
      end
    end
  end

  assign is_last = (i_q == head.rows.last) && (j_q == head.cols.last);
  assign o_ready = !out_valid || !out_stall;
  assign s_ready = !s_valid || o_ready;
  assign issue   = !q_stat.empty && s_ready;
  assign pop     = issue && is_last;

  // Step through the output block
  always_ff @(posedge clk) begin
    if (rst) begin
      i_q <= '0;
      j_q <= '0;
    end else if (issue) begin
      if (j_q == head.cols.last) begin
        j_q <= '0;
        i_q <= is_last ? 2'd0 : i_q + 2'd1;
      end else begin
        j_q <= j_q + 2'd1;
      end
    end
  end

  // Sum and output stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_ready) begin
        s_valid <= issue;
      end
      if (o_ready) begin
        out_valid <= s_valid;
      end
    end
  end

  // Hold sums, position and last flag
  always_ff @(posedge clk) begin
    if (issue) begin
      s_r    <= sum_r;
      s_g    <= sum_g;
      s_b    <= sum_b;
      s_row  <= head.rows.base + bb3_pkg::POS_W'(i_q);
      s_col  <= head.cols.base + bb3_pkg::POS_W'(j_q);
      s_last <= is_last;
    end
  end

  // Divide by nine into the output register
  always_ff @(posedge clk) begin
    if (o_ready && s_valid) begin
      out_red     <= div9(s_r);
      out_green   <= div9(s_g);
      out_blue    <= div9(s_b);
      out_row     <= s_row;
      out_col     <= s_col;
      last_of_run <= s_last;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/box_blur_3x3_forward_window_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Path to a result: stage A, the job queue, the sum stage and the output register.
// Throughput, while the output is not stalled: one pixel per cycle while each pixel
// yields at most one result; an edge pixel yields up to nine results, issued one per
// cycle by the back-end sequencer, with a 4-entry job queue absorbing the burst
// before the input stalls. Reset clears position counters, queue and pipeline valids,
// and sets both dimension registers to 512; line store and window hold no reset value.
// ----------------------------------------------------------------------------
// box_blur_3x3_forward_window_top: 3x3 forward box blur over an RGB stream
// Configuration registers, dimension clamping and the front, queue and
// back end of the blur.
// ----------------------------------------------------------------------------
module box_blur_3x3_forward_window_top #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bb3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bb3_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bb3_pkg::CH_W-1:0]          red,
  input  wire logic [bb3_pkg::CH_W-1:0]          green,
  input  wire logic [bb3_pkg::CH_W-1:0]          blue,
  input  wire logic                              frame_start,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bb3_pkg::CH_W-1:0]               out_red,
  output logic [bb3_pkg::CH_W-1:0]               out_green,
  output logic [bb3_pkg::CH_W-1:0]               out_blue,
  output logic [bb3_pkg::POS_W-1:0]              out_row,
  output logic [bb3_pkg::POS_W-1:0]              out_col,
  output logic                                   last_of_run
);

  localparam int WDW = $clog2(MAX_WIDTH + 1);
  localparam int HDW = $clog2(MAX_HEIGHT + 1);

  logic [bb3_pkg::CFG_W-1:0] width_in_use, height_in_use;
  logic [WDW-1:0]            w_eff;
  logic [HDW-1:0]            h_eff;

  logic               q_push, q_pop;
  bb3_pkg::job_t      push_job, head_job;
  bb3_pkg::q_stat_t   q_stat;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= bb3_pkg::CFG_DIM_RESET;
      height_in_use <= bb3_pkg::CFG_DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bb3_pkg::CFG_WIDTH:  width_in_use  <= cfg_data;
        bb3_pkg::CFG_HEIGHT: height_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp dimensions to 1..maximum
  always_comb begin
    if (width_in_use == '0) begin
      w_eff = WDW'(1);
    end else if (32'(width_in_use) > MAX_WIDTH) begin
      w_eff = WDW'(MAX_WIDTH);
    end else begin
      w_eff = WDW'(width_in_use);
    end
    if (height_in_use == '0) begin
      h_eff = HDW'(1);
    end else if (32'(height_in_use) > MAX_HEIGHT) begin
      h_eff = HDW'(MAX_HEIGHT);
    end else begin
      h_eff = HDW'(height_in_use);
    end
  end

  bb3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .w           (w_eff),
    .h           (h_eff),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .frame_start (frame_start),
    .q_stat      (q_stat),
    .push        (q_push),
    .job         (push_job)
  );

  bb3_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head_job),
    .stat     (q_stat)
  );

  bb3_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head_job),
    .q_stat      (q_stat),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_of_run (last_of_run)
  );

  // The front end only pushes into a queue with room
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  // The back end only pops a job that is present
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_stat.empty)
    else $error("job popped from an empty queue");

  // Input backpressure comes only from a full job queue
  assert property (@(posedge clk) disable iff (rst) in_stall |-> q_stat.full)
    else $error("input stalled while the job queue has room");

endmodule
`default_nettype wire
